// ----- hw/rtl/dijkstra_shortest_paths_unit_assert.svh -----
// Assertion macros shared by the checker of the shortest path unit
`ifndef DIJKSTRA_SHORTEST_PATHS_UNIT_ASSERT_SVH
`define DIJKSTRA_SHORTEST_PATHS_UNIT_ASSERT_SVH
// same-cycle implication, sampled on clk, off during rst
`define DSP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk, off during rst
`define DSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- hw/rtl/dsp_pkg.sv -----
// Types and constants of the shortest path unit
package dsp_pkg;
  localparam int MAX_VERTICES = 1024;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int VCNT_W       = VTX_W + 1;
  localparam int MAX_EDGES    = 8192;
  localparam int EDGE_W       = $clog2(MAX_EDGES);
  localparam int EPTR_W       = EDGE_W + 1;
  localparam int WEIGHT_BITS  = 16;
  localparam int QUEUE_DEPTH  = 8192;
  localparam int QADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = QADDR_W + 1;
  localparam int DIST_W       = 32;

  typedef enum logic [1:0] {
    CMD_LOAD_END  = 2'd0,
    CMD_LOAD_EDGE = 2'd1,
    CMD_RUN       = 2'd2,
    CMD_READ      = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [12:0] index;
    logic [9:0]  vertex;
    logic [13:0] offset_value;
    logic [15:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  vertex_out;
    logic [31:0] distance;
    logic [9:0]  predecessor;
    logic        reached;
    logic        status;
  } out_item_t;

  typedef struct packed {
    logic [VTX_W-1:0]       target;
    logic [WEIGHT_BITS-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic [DIST_W-1:0] cost;
    logic [VTX_W-1:0]  vtx;
  } q_entry_t;

  typedef struct packed {
    logic     clear;
    logic     push;
    logic     pop;
    q_entry_t entry;
  } q_ctrl_t;

  typedef struct packed {
    logic     busy;
    logic     empty;
    logic     overflow;
    logic     pop_done;
    q_entry_t top;
  } q_stat_t;

  // clamp a stored end offset to the edge table size
  function automatic logic [EPTR_W-1:0] clamp_end(input logic [13:0] off);
    logic [EPTR_W-1:0] r;
    if (EPTR_W'(off) > EPTR_W'(MAX_EDGES)) r = EPTR_W'(MAX_EDGES);
    else r = EPTR_W'(off);
    return r;
  endfunction
endpackage

// ----- hw/rtl/dsp_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module dsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/dsp_queue.sv -----
// Lazy priority queue: push at the tail, pop the first minimum by scan and shift
module dsp_queue (
  input  logic             clk,
  input  logic             rst,
  input  dsp_pkg::q_ctrl_t ctrl,
  output dsp_pkg::q_stat_t stat
);
  import dsp_pkg::*;

  typedef enum logic [1:0] {Q_IDLE, Q_SCAN, Q_SHIFT} qstate_t;

  qstate_t             state;
  logic [QCNT_W-1:0]   count;
  logic                overflow;
  logic                pop_done;
  logic [QCNT_W-1:0]   scan_addr;
  logic [QCNT_W-1:0]   shift_addr;
  logic                rd_valid;
  logic [QADDR_W-1:0]  rd_idx;
  q_entry_t            best;
  logic [QADDR_W-1:0]  best_idx;
  logic [QADDR_W-1:0]  best_idx_next;
  logic                cand_better;
  logic                last_scan;

  logic                we;
  logic [QADDR_W-1:0]  waddr;
  q_entry_t            wdata;
  logic [QADDR_W-1:0]  raddr;
  q_entry_t            rdata;

  dsp_ram #(.WIDTH($bits(q_entry_t)), .DEPTH(QUEUE_DEPTH)) u_qram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // strictly smaller keeps the earliest entry among equal keys
  assign cand_better   = rd_valid && ((rd_idx == '0) || (rdata.cost < best.cost));
  assign best_idx_next = cand_better ? rd_idx : best_idx;
  assign last_scan     = rd_valid && ({1'b0, rd_idx} == (count - 1'b1));

  always_comb begin
    we    = 1'b0;
    waddr = count[QADDR_W-1:0];
    wdata = ctrl.entry;
    raddr = scan_addr[QADDR_W-1:0];
    unique case (state)
      Q_IDLE: begin
        we = ctrl.push && !ctrl.clear && (count != QCNT_W'(QUEUE_DEPTH));
      end
      Q_SCAN: begin
        raddr = scan_addr[QADDR_W-1:0];
      end
      Q_SHIFT: begin
        raddr = shift_addr[QADDR_W-1:0];
        if (rd_valid) begin
          // move the entry one slot toward the head
          we    = 1'b1;
          waddr = rd_idx - 1'b1;
          wdata = rdata;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= Q_IDLE;
      count    <= '0;
      overflow <= 1'b0;
      pop_done <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      pop_done <= 1'b0;
      if (ctrl.clear) begin
        state    <= Q_IDLE;
        count    <= '0;
        overflow <= 1'b0;
        rd_valid <= 1'b0;
      end else begin
        unique case (state)
          Q_IDLE: begin
            if (ctrl.push) begin
              if (count == QCNT_W'(QUEUE_DEPTH)) overflow <= 1'b1;
              else count <= count + 1'b1;
            end else if (ctrl.pop) begin
              state     <= Q_SCAN;
              scan_addr <= '0;
              rd_valid  <= 1'b0;
            end
          end
          Q_SCAN: begin
            rd_valid <= scan_addr < count;
            rd_idx   <= scan_addr[QADDR_W-1:0];
            if (scan_addr < count) scan_addr <= scan_addr + 1'b1;
            if (cand_better) begin
              best     <= rdata;
              best_idx <= rd_idx;
            end
            if (last_scan) begin
              state      <= Q_SHIFT;
              shift_addr <= {1'b0, best_idx_next} + 1'b1;
              rd_valid   <= 1'b0;
            end
          end
          Q_SHIFT: begin
            rd_valid <= shift_addr < count;
            rd_idx   <= shift_addr[QADDR_W-1:0];
            if (shift_addr < count) shift_addr <= shift_addr + 1'b1;
            if (!rd_valid && !(shift_addr < count)) begin
              count    <= count - 1'b1;
              pop_done <= 1'b1;
              state    <= Q_IDLE;
            end
          end
          default: state <= Q_IDLE;
        endcase
      end
    end
  end

  assign stat.busy     = state != Q_IDLE;
  assign stat.empty    = count == '0;
  assign stat.overflow = overflow;
  assign stat.pop_done = pop_done;
  assign stat.top      = best;
endmodule

// ----- hw/rtl/dijkstra_shortest_paths_unit.sv -----
// Top level of the single-source shortest path unit
// A transaction is accepted when start is high and busy is low. Load commands
// (end offset, edge) leave the unit idle, so loads stream one per cycle. A read
// passes through the output state and returns its result with a registered done.
// A run first clears the distance and predecessor memories, then per popped
// entry scans the queue (the minimum scan and the shift that removes it),
// fetches the edge range (start and end offsets) and walks each edge (edge read,
// then distance read and update for targets in the active range), so its
// length follows the graph; done then reports the source. After reset the same
// clearing pass runs with busy high; configuration writes are taken at any
// time. Results are shown for one cycle and cannot be held.
module dijkstra_shortest_paths_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  dsp_pkg::in_item_t  item,
  output logic               done,
  output dsp_pkg::out_item_t result,
  input  logic               cfg_we,
  input  logic [10:0]        cfg_wdata
);
  import dsp_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SEED, S_LOOP, S_POP_WAIT, S_END_A, S_END_B,
    S_EDGE, S_EDGE_WAIT, S_DIST_WAIT, S_OUT
  } state_t;

  state_t              state;
  logic [VTX_W-1:0]    clr_addr;
  logic                run_flag;
  logic [VTX_W-1:0]    cur_vtx;
  logic [VCNT_W-1:0]   vertex_count;
  logic [VCNT_W-1:0]   n_active;
  logic [VCNT_W-1:0]   n_next;
  logic [VTX_W-1:0]    from_vtx;
  logic [DIST_W-1:0]   from_dist;
  logic [EPTR_W-1:0]   e_ptr;
  logic [EPTR_W-1:0]   e_end;
  logic [VTX_W-1:0]    edge_to;
  logic [WEIGHT_BITS-1:0] edge_w;
  logic                accept;

  logic                end_we;
  logic [VTX_W-1:0]    end_raddr;
  logic [13:0]         end_rdata;
  logic                edge_we;
  logic [EDGE_W-1:0]   edge_raddr;
  edge_t               edge_wdata;
  edge_t               edge_rdata;
  logic                path_we;
  logic [VTX_W-1:0]    path_waddr;
  logic [DIST_W-1:0]   dist_wdata;
  logic [VTX_W-1:0]    pred_wdata;
  logic [VTX_W-1:0]    path_raddr;
  logic [DIST_W-1:0]   dist_rdata;
  logic [VTX_W-1:0]    pred_rdata;
  logic [DIST_W:0]     sum;
  logic                shorter;
  q_ctrl_t             qc;
  q_stat_t             qs;

  assign busy   = state != S_IDLE;
  assign accept = start && !busy;

  always_comb begin
    if (vertex_count == '0) n_next = VCNT_W'(1);
    else if (vertex_count > VCNT_W'(MAX_VERTICES)) n_next = VCNT_W'(MAX_VERTICES);
    else n_next = vertex_count;
  end

  assign sum     = {1'b0, from_dist} + (DIST_W + 1)'(edge_w);
  assign shorter = sum < {1'b0, dist_rdata};

  dsp_ram #(.WIDTH(14), .DEPTH(MAX_VERTICES)) u_end_ram (
    .clk   (clk),
    .we    (end_we),
    .waddr (item.index[VTX_W-1:0]),
    .wdata (item.offset_value),
    .raddr (end_raddr),
    .rdata (end_rdata)
  );

  assign edge_wdata = '{target: item.vertex, weight: item.weight};

  dsp_ram #(.WIDTH($bits(edge_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (item.index[EDGE_W-1:0]),
    .wdata (edge_wdata),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  dsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_dist_ram (
    .clk   (clk),
    .we    (path_we),
    .waddr (path_waddr),
    .wdata (dist_wdata),
    .raddr (path_raddr),
    .rdata (dist_rdata)
  );

  dsp_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_pred_ram (
    .clk   (clk),
    .we    (path_we),
    .waddr (path_waddr),
    .wdata (pred_wdata),
    .raddr (path_raddr),
    .rdata (pred_rdata)
  );

  dsp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .ctrl (qc),
    .stat (qs)
  );

  always_comb begin
    end_we     = accept && (item.cmd == CMD_LOAD_END) &&
                 (item.index < 13'(MAX_VERTICES));
    edge_we    = accept && (item.cmd == CMD_LOAD_EDGE);
    end_raddr  = from_vtx;
    edge_raddr = e_ptr[EDGE_W-1:0];
    path_we    = 1'b0;
    path_waddr = edge_to;
    dist_wdata = sum[DIST_W-1:0];
    pred_wdata = from_vtx;
    path_raddr = cur_vtx;
    qc.clear   = accept && (item.cmd == CMD_RUN);
    qc.push    = 1'b0;
    qc.pop     = 1'b0;
    qc.entry   = '{cost: sum[DIST_W-1:0], vtx: edge_to};
    unique case (state)
      S_CLEAR: begin
        path_we    = 1'b1;
        path_waddr = clr_addr;
        dist_wdata = '1;
        pred_wdata = clr_addr;
      end
      S_IDLE: begin
        path_raddr = item.vertex;
      end
      S_SEED: begin
        path_we    = 1'b1;
        path_waddr = cur_vtx;
        dist_wdata = '0;
        pred_wdata = cur_vtx;
        qc.push    = 1'b1;
        qc.entry   = '{cost: '0, vtx: cur_vtx};
      end
      S_LOOP: begin
        qc.pop = !qs.empty;
      end
      S_POP_WAIT: begin
        end_raddr = qs.top.vtx - 1'b1;
      end
      S_EDGE_WAIT: begin
        path_raddr = edge_rdata.target;
      end
      S_DIST_WAIT: begin
        path_we = shorter;
        qc.push = shorter;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      run_flag     <= 1'b0;
      done         <= 1'b0;
      vertex_count <= VCNT_W'(MAX_VERTICES);
    end else begin
      done <= 1'b0;
      if (cfg_we) vertex_count <= cfg_wdata;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == VTX_W'(MAX_VERTICES - 1)) begin
            if (!run_flag) state <= S_IDLE;
            else if ({1'b0, cur_vtx} < n_active) state <= S_SEED;
            else state <= S_LOOP;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cur_vtx <= item.vertex;
            if (item.cmd == CMD_RUN) begin
              n_active <= n_next;
              run_flag <= 1'b1;
              clr_addr <= '0;
              state    <= S_CLEAR;
            end else if (item.cmd == CMD_READ) begin
              state <= S_OUT;
            end
          end
        end
        S_SEED: state <= S_LOOP;
        S_LOOP: begin
          // empty queue: the source read was issued this cycle
          if (qs.empty) state <= S_OUT;
          else state <= S_POP_WAIT;
        end
        S_POP_WAIT: begin
          if (qs.pop_done) begin
            from_vtx  <= qs.top.vtx;
            from_dist <= qs.top.cost;
            state     <= S_END_A;
          end
        end
        S_END_A: begin
          e_ptr <= (from_vtx == '0) ? '0 : clamp_end(end_rdata);
          state <= S_END_B;
        end
        S_END_B: begin
          e_end <= clamp_end(end_rdata);
          state <= S_EDGE;
        end
        S_EDGE: begin
          if (e_ptr >= e_end) begin
            state <= S_LOOP;
          end else begin
            e_ptr <= e_ptr + 1'b1;
            state <= S_EDGE_WAIT;
          end
        end
        S_EDGE_WAIT: begin
          edge_to <= edge_rdata.target;
          edge_w  <= edge_rdata.weight;
          // drop edges to vertices outside the active range
          if ({1'b0, edge_rdata.target} >= n_active) state <= S_EDGE;
          else state <= S_DIST_WAIT;
        end
        S_DIST_WAIT: state <= S_EDGE;
        S_OUT: begin
          result.vertex_out  <= cur_vtx;
          result.distance    <= dist_rdata;
          result.predecessor <= pred_rdata;
          result.reached     <= dist_rdata != '1;
          result.status      <= qs.overflow;
          done               <= 1'b1;
          state              <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hw/rtl/dsp_checker.sv -----
// Port-level checker for the shortest path unit, bound to the top level
`include "dijkstra_shortest_paths_unit_assert.svh"
module dsp_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input dsp_pkg::in_item_t  item,
  input logic               done,
  input dsp_pkg::out_item_t result
);
  import dsp_pkg::*;

  logic acc_read;
  logic acc_load;

  assign acc_read = start && !busy && (item.cmd == CMD_READ);
  assign acc_load = start && !busy &&
                    ((item.cmd == CMD_LOAD_END) || (item.cmd == CMD_LOAD_EDGE));

  `DSP_ASSERT_NEXT(a_done_single, done, !done, "done held for more than one cycle")
  `DSP_ASSERT_NEXT(a_load_one_cycle, acc_load, !busy, "load did not finish in one cycle")
  `DSP_ASSERT_IMPL(a_read_latency, acc_read, ##2 done, "read result not on time")
  `DSP_ASSERT_IMPL(a_reached_match, done, result.reached == (result.distance != '1),
                   "reached disagrees with distance")
endmodule

bind dijkstra_shortest_paths_unit dsp_checker u_dsp_checker (.*);

// ----- tb/sv/dijkstra_shortest_paths_unit_tb.sv -----
// Self-checking testbench of the single-source shortest path unit
module dijkstra_shortest_paths_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dsp_pkg::*;

  typedef struct {
    bit [31:0] cost;
    bit [9:0]  vtx;
  } frontier_ent_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  cmd_item = '0;
  logic      done;
  out_item_t result;
  logic      cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;

  dijkstra_shortest_paths_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (cmd_item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the graph and path state
  bit [13:0] sp_end[MAX_VERTICES];
  bit [9:0]  sp_target[MAX_EDGES];
  bit [15:0] sp_weight[MAX_EDGES];
  bit [31:0] sp_dist[MAX_VERTICES];
  bit [9:0]  sp_pred[MAX_VERTICES];
  bit        sp_overflow;
  int unsigned sp_vcount = MAX_VERTICES;
  frontier_ent_t frontier[$];

  in_item_t  pending_cmds[$];
  out_item_t expected_reports[$];

  // what the stimulus has written so far, to keep runs on loaded entries
  bit        gen_end_wr[MAX_VERTICES];
  bit [13:0] gen_end[MAX_VERTICES];
  bit        gen_edge_wr[MAX_EDGES];
  bit [9:0]  gen_target[MAX_EDGES];
  int unsigned gen_n = MAX_VERTICES;

  int errors = 0;
  int n_runs = 0, n_reads = 0, n_loads = 0, n_phases = 0;

  function automatic int unsigned active_vertices(int unsigned c);
    if (c == 0) return 1;
    if (c > MAX_VERTICES) return MAX_VERTICES;
    return c;
  endfunction

  function automatic int unsigned clip_edge(bit [13:0] e);
    return (e > MAX_EDGES) ? MAX_EDGES : e;
  endfunction

  function automatic void clear_paths();
    for (int v = 0; v < MAX_VERTICES; v++) begin
      sp_dist[v] = '1;
      sp_pred[v] = v[9:0];
    end
    frontier.delete();
    sp_overflow = 1'b0;
  endfunction

  function automatic void add_frontier(bit [9:0] v, bit [31:0] d);
    frontier_ent_t e;
    e.cost = d;
    e.vtx = v;
    if (frontier.size() >= QUEUE_DEPTH) sp_overflow = 1'b1;
    else frontier.push_back(e);
  endfunction

  function automatic void solve_paths(bit [9:0] src);
    int unsigned n;
    int best;
    int unsigned lo, hi;
    frontier_ent_t e;
    bit [32:0] sum;
    bit [9:0] to;
    n = active_vertices(sp_vcount);
    clear_paths();
    if (src >= n) return;
    sp_dist[src] = '0;
    add_frontier(src, '0);
    while (frontier.size() > 0) begin
      best = 0;
      for (int i = 1; i < frontier.size(); i++)
        if (frontier[i].cost < frontier[best].cost) best = i;
      e = frontier[best];
      frontier.delete(best);
      lo = (e.vtx == 0) ? 0 : clip_edge(sp_end[e.vtx - 1]);
      hi = clip_edge(sp_end[e.vtx]);
      for (int unsigned i = lo; i < hi; i++) begin
        to = sp_target[i];
        if (to < n) begin
          sum = {1'b0, e.cost} + 33'(sp_weight[i]);
          if (sum < {1'b0, sp_dist[to]}) begin
            sp_dist[to] = sum[31:0];
            sp_pred[to] = e.vtx;
            add_frontier(to, sum[31:0]);
          end
        end
      end
    end
  endfunction

  function automatic void predict_command(in_item_t it);
    out_item_t r;
    case (cmd_t'(it.cmd))
      CMD_LOAD_END: begin
        if (it.index < MAX_VERTICES) sp_end[it.index] = it.offset_value;
        n_loads++;
      end
      CMD_LOAD_EDGE: begin
        sp_target[it.index] = it.vertex;
        sp_weight[it.index] = it.weight;
        n_loads++;
      end
      default: begin
        if (cmd_t'(it.cmd) == CMD_RUN) begin
          solve_paths(it.vertex);
          n_runs++;
        end else begin
          n_reads++;
        end
        r.vertex_out  = it.vertex;
        r.distance    = sp_dist[it.vertex];
        r.predecessor = sp_pred[it.vertex];
        r.reached     = (sp_dist[it.vertex] != '1);
        r.status      = sp_overflow;
        expected_reports.push_back(r);
      end
    endcase
  endfunction

  // driver: bursts of transactions with random gaps
  int burst_left = 1, gap_left = 0;
  always @(posedge clk) begin
    if (!rst && start && !busy) predict_command(cmd_item);
    if (rst || (start && busy)) begin
      // hold
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (pending_cmds.size() > 0) begin
      start <= 1'b1;
      cmd_item <= pending_cmds.pop_front();
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && done) begin
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected report: vertex %0d", result.vertex_out);
      end else begin
        exp_r = expected_reports.pop_front();
        if (result.vertex_out !== exp_r.vertex_out || result.distance !== exp_r.distance ||
            result.predecessor !== exp_r.predecessor || result.reached !== exp_r.reached ||
            result.status !== exp_r.status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp v=%0d d=%h p=%0d r=%b s=%b, got v=%0d d=%h p=%0d r=%b s=%b",
                     exp_r.vertex_out, exp_r.distance, exp_r.predecessor, exp_r.reached,
                     exp_r.status, result.vertex_out, result.distance,
                     result.predecessor, result.reached, result.status);
        end
      end
    end
  end

  function automatic void queue_cmd(cmd_t c, int unsigned idx, int unsigned v,
                                    int unsigned off, int unsigned w);
    in_item_t it;
    it.cmd = c;
    it.index = idx[12:0];
    it.vertex = v[9:0];
    it.offset_value = off[13:0];
    it.weight = w[15:0];
    if (c == CMD_LOAD_END && it.index < MAX_VERTICES) begin
      gen_end_wr[it.index] = 1'b1;
      gen_end[it.index] = it.offset_value;
    end
    if (c == CMD_LOAD_EDGE) begin
      gen_edge_wr[it.index] = 1'b1;
      gen_target[it.index] = it.vertex;
    end
    pending_cmds.push_back(it);
  endfunction

  // load whatever a run could reach from its source before issuing it
  function automatic void queue_run(int unsigned src);
    int unsigned lo, hi, v;
    bit seen[MAX_VERTICES];
    int unsigned work[$];
    if (src < gen_n) begin
      seen[src] = 1'b1;
      work.push_back(src);
    end
    while (work.size() > 0) begin
      v = work.pop_front();
      if (v > 0 && !gen_end_wr[v - 1])
        queue_cmd(CMD_LOAD_END, v - 1, 0, $urandom_range(0, 48), 0);
      if (!gen_end_wr[v]) queue_cmd(CMD_LOAD_END, v, 0, $urandom_range(0, 48), 0);
      lo = (v == 0) ? 0 : clip_edge(gen_end[v - 1]);
      hi = clip_edge(gen_end[v]);
      for (int unsigned i = lo; i < hi; i++) begin
        if (!gen_edge_wr[i])
          queue_cmd(CMD_LOAD_EDGE, i, $urandom_range(0, gen_n - 1), 0, $urandom_range(0, 300));
        if (gen_target[i] < gen_n && !seen[gen_target[i]]) begin
          seen[gen_target[i]] = 1'b1;
          work.push_back(gen_target[i]);
        end
      end
    end
    queue_cmd(CMD_RUN, 0, src, 0, 0);
  endfunction

  function automatic int unsigned pick_vertex();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, gen_n - 1);
  endfunction

  function automatic void queue_random(int count);
    int sel;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35)
        queue_cmd(CMD_LOAD_EDGE,
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 63),
                  pick_vertex(), $urandom_range(0, 16383),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 20));
      else if (sel < 50) begin
        if ($urandom_range(0, 6) == 0)
          queue_cmd(CMD_LOAD_END, $urandom_range(1024, 8191), $urandom_range(0, 1023),
                    $urandom_range(0, 16383), $urandom_range(0, 65535));
        else
          queue_cmd(CMD_LOAD_END, $urandom_range(0, gen_n - 1), 0, $urandom_range(0, 48), 0);
      end else if (sel < 62)
        queue_run(pick_vertex());
      else
        queue_cmd(CMD_READ, $urandom_range(0, 8191), pick_vertex(), 0, 0);
    end
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || start || expected_reports.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_vertex_count(int unsigned c);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= c[10:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sp_vcount = c;
    gen_n = active_vertices(c);
    n_phases++;
    @(negedge clk);
  endtask

  initial begin
    clear_paths();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    set_vertex_count(1024);
    queue_cmd(CMD_READ, 0, 0, 0, 0);
    queue_cmd(CMD_READ, 8191, 1023, 16383, 65535);
    queue_cmd(CMD_LOAD_END, 8191, 1023, 16383, 65535);
    queue_cmd(CMD_LOAD_END, 1024, 0, 0, 0);
    queue_cmd(CMD_LOAD_END, 0, 0, 3, 0);
    queue_cmd(CMD_LOAD_END, 1, 0, 4, 0);
    queue_cmd(CMD_LOAD_END, 2, 0, 5, 0);
    queue_cmd(CMD_LOAD_END, 3, 0, 5, 0);
    queue_cmd(CMD_LOAD_END, 4, 0, 3, 0);          // start above end: no edges
    queue_cmd(CMD_LOAD_EDGE, 0, 1, 0, 65535);
    queue_cmd(CMD_LOAD_EDGE, 1, 2, 0, 5);
    queue_cmd(CMD_LOAD_EDGE, 2, 3, 0, 5);         // ties with vertex 2
    queue_cmd(CMD_LOAD_EDGE, 3, 2, 0, 0);
    queue_cmd(CMD_LOAD_EDGE, 4, 1, 0, 1);         // shorter path leaves a stale entry
    queue_cmd(CMD_LOAD_EDGE, 8191, 1023, 0, 65535);
    queue_run(0);
    queue_cmd(CMD_READ, 0, 1, 0, 0);
    queue_cmd(CMD_READ, 0, 2, 0, 0);
    queue_cmd(CMD_READ, 0, 3, 0, 0);
    queue_cmd(CMD_READ, 0, 1023, 0, 0);
    queue_run(1023);

    // clamped end offset on the source's last edges, then a source beyond the vertex count
    set_vertex_count(4);
    queue_cmd(CMD_LOAD_END, 1, 0, 8190, 0);
    queue_cmd(CMD_LOAD_END, 2, 0, 16383, 0);
    queue_cmd(CMD_LOAD_EDGE, 8190, 3, 0, 7);
    queue_run(2);
    queue_cmd(CMD_READ, 0, 3, 0, 0);
    queue_cmd(CMD_LOAD_END, 1, 0, 4, 0);
    queue_cmd(CMD_LOAD_END, 2, 0, 5, 0);
    queue_run(1023);
    queue_cmd(CMD_READ, 0, 900, 0, 0);

    set_vertex_count(0);
    queue_random(40);
    set_vertex_count(1);
    queue_random(40);
    for (int p = 0; p < 6; p++) begin
      set_vertex_count($urandom_range(2, 24));
      queue_random(50);
    end
    set_vertex_count(2047);
    queue_random(50);

    wait_idle();
    repeat (40) @(negedge clk);
    $display("Covered %0d runs, %0d reads and %0d loads over %0d vertex count settings",
             n_runs, n_reads, n_loads, n_phases);
    $display("%0d mismatches", errors);
    if (errors == 0 && expected_reports.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #40ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
